// ===== hdl/idb_pkg.sv =====
// shared types, constants and the window check for the switch debounce block
`timescale 1ns / 1ps

package idb_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSamplePeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIntegratorMax = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFaultLimit    = 2'd2;

  // register reset values
  localparam logic [TimeW-1:0]  SamplePeriodRst  = 32'd1;
  localparam logic [CountW-1:0] IntegratorMaxRst = 8'd5;
  localparam logic [TimeW-1:0]  FaultLimitRst    = 32'd2000;

  // edge codes
  localparam logic [1:0] EdgeNone    = 2'd0;
  localparam logic [1:0] EdgeRising  = 2'd1;
  localparam logic [1:0] EdgeFalling = 2'd2;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusNotOk = 1'b1;

  typedef logic [TimeW-1:0] time_ms_t;

  // wrap-aware early check against last + span
  function automatic logic too_early(time_ms_t now, time_ms_t last, time_ms_t span);
    time_ms_t upper;
    logic     res;
    upper = last + span;
    if ((now < last) && (upper > last)) begin
      res = 1'b0;
    end else if ((now > last) && (upper < last)) begin
      res = 1'b1;
    end else begin
      res = (now < upper);
    end
    return res;
  endfunction

endpackage

// ===== hdl/integrator_debounce_with_edge_detect_core.sv =====
// integrator switch debounce with window check, fault timer and edge detector
`timescale 1ns / 1ps

// Usage
//   s_axis: one beat per sample, raw switch level and a wrapping ms timestamp.
//   m_axis: one beat per sample: status, debounced level and edge code.
//   cfg_*:  write-only register port (sample period, integrator max, fault limit);
//           the user writes it only while no sample is in flight; not enforced.
// Each beat is held in the input register; the integrator, window checks and
// edge detector then settle in one pass into the result register, which also
// updates the state unless the sample is early. Throughput is one sample per
// cycle unless the receiver stalls; the state loop closes in that single
// pass, so back-to-back samples each see the state left by the one before.
// A stalled receiver holds the result register; the input register still
// takes one more beat, and s_tready falls only when both are full.
// Reset clears the state (times, integrator, stable and edge levels), loads
// the register reset values and empties both registers; no beat is lost or
// repeated across a stall.
module integrator_debounce_with_edge_detect_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [idb_pkg::InDataW-1:0]    s_tdata,   // raw_level, now_ms[31:0], zero pad
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [idb_pkg::OutDataW-1:0]   m_tdata,   // status, debounced_level, edge_res[1:0], zero pad
  input  logic                           cfg_we,
  input  logic [idb_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [idb_pkg::CfgW-1:0]       cfg_data
);
  import idb_pkg::*;

  // configuration
  time_ms_t          sample_period_ms;
  logic [CountW-1:0] integrator_max;
  time_ms_t          fault_limit_ms;

  // state
  time_ms_t          last_sample_ms;
  logic [CountW-1:0] integrator_count;
  logic              stable_level;
  time_ms_t          last_stable_ms;
  logic              edge_last_level;

  // input register
  logic     in_valid;
  logic     in_raw;
  time_ms_t in_now;

  // result register
  logic       out_valid;
  logic       out_status;
  logic       out_level;
  logic [1:0] out_edge;

  logic advance;

  // next values
  logic              early;
  logic [CountW-1:0] count_step;
  logic [CountW-1:0] integrator_count_next;
  logic              stable_level_next;
  time_ms_t          last_stable_ms_next;
  logic              stamped;
  logic              fault_keep;
  logic              fault_stamp;
  logic              fault;
  logic              edge_last_level_next;
  logic              status_next;
  logic              level_next;
  logic [1:0]        edge_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period_ms <= SamplePeriodRst;
      integrator_max   <= IntegratorMaxRst;
      fault_limit_ms   <= FaultLimitRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegSamplePeriod:  sample_period_ms <= cfg_data;
        RegIntegratorMax: integrator_max   <= cfg_data[CountW-1:0];
        RegFaultLimit:    fault_limit_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_raw <= s_tdata[0];
      in_now <= s_tdata[TimeW:1];
    end
  end

  always_comb begin
    early = too_early(in_now, last_sample_ms, sample_period_ms);

    // saturating integrator step
    count_step = integrator_count;
    if (!in_raw) begin
      if (integrator_count != '0) count_step = integrator_count - 1'b1;
    end else if (integrator_count < integrator_max) begin
      count_step = integrator_count + 1'b1;
    end

    integrator_count_next = count_step;
    stable_level_next     = stable_level;
    stamped               = 1'b0;
    priority if (count_step == '0) begin
      stable_level_next = 1'b0;
      stamped           = 1'b1;
    end else if (count_step >= integrator_max) begin
      stable_level_next     = 1'b1;
      stamped               = 1'b1;
      integrator_count_next = integrator_max;
    end
    last_stable_ms_next = stamped ? in_now : last_stable_ms;

    // both fault candidates in parallel, picked by the stamp
    fault_keep  = !too_early(in_now, last_stable_ms, fault_limit_ms);
    fault_stamp = !too_early(in_now, in_now, fault_limit_ms);
    fault       = stamped ? fault_stamp : fault_keep;

    edge_last_level_next = edge_last_level;
    edge_next            = EdgeNone;
    status_next          = StatusNotOk;
    level_next           = 1'b0;
    if (!early && !fault) begin
      status_next = StatusOk;
      level_next  = stable_level_next;
      if (stable_level_next != edge_last_level) begin
        edge_last_level_next = stable_level_next;
        edge_next            = stable_level_next ? EdgeRising : EdgeFalling;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_ms   <= '0;
      integrator_count <= '0;
      stable_level     <= 1'b0;
      last_stable_ms   <= '0;
      edge_last_level  <= 1'b0;
    end else if (advance && !early) begin
      last_sample_ms   <= in_now;
      integrator_count <= integrator_count_next;
      stable_level     <= stable_level_next;
      last_stable_ms   <= last_stable_ms_next;
      edge_last_level  <= edge_last_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status_next;
      out_level  <= level_next;
      out_edge   <= edge_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW-4){1'b0}}, out_edge, out_level, out_status};

  // a not-ok result carries no level and no edge
  a_notok_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[3:1] == 3'b000))
    else $error("not-ok result carries level or edge");

  // a reported edge agrees with the reported level
  a_edge_level: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[3:2] != EdgeNone)) |->
      ((m_tdata[3:2] == EdgeRising && m_tdata[1]) ||
       (m_tdata[3:2] == EdgeFalling && !m_tdata[1])))
    else $error("edge code disagrees with level");

  // an early sample leaves the state alone
  a_early_hold: assert property (@(posedge clk) disable iff (rst)
    (advance && early) |=>
      ($stable(last_sample_ms) && $stable(integrator_count) && $stable(edge_last_level)))
    else $error("early sample changed state");

  // the edge tracker only moves on an ok result
  a_edge_tracker: assert property (@(posedge clk) disable iff (rst)
    (advance && status_next == StatusNotOk) |=> $stable(edge_last_level))
    else $error("edge tracker moved on a not-ok sample");

endmodule
